// File: rtl/core/krt_pkg.sv
// Shared types, constants and operation codes for the keyed ranking table.
package krt_pkg;
    localparam int CAPACITY_DEF    = 1024;
    localparam int NUM_FACTORS_DEF = 4;

    typedef enum logic [2:0] {
        OP_SET_ALL = 3'd0,
        OP_SET_ONE = 3'd1,
        OP_DELETE  = 3'd2,
        OP_RANK    = 3'd3,
        OP_KEY_AT  = 3'd4,
        OP_FACTORS = 3'd5,
        OP_RSVD6   = 3'd6,
        OP_RSVD7   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_BADIDX   = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        key;
        logic signed [31:0] factor_0;
        logic signed [31:0] factor_1;
        logic signed [31:0] factor_2;
        logic signed [31:0] factor_3;
        logic [2:0]         factor_count;
        logic [3:0]         factor_index;
        logic [10:0]        position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [10:0]        new_position;
        logic [10:0]        old_position;
        logic [31:0]        result_key;
        logic signed [31:0] out_factor_0;
        logic signed [31:0] out_factor_1;
        logic signed [31:0] out_factor_2;
        logic signed [31:0] out_factor_3;
        logic [2:0]         factors_used;
    } t_out_item;

    // memory port request from the sequencer
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [15:0] rd_addr;
        logic [15:0] wr_addr;
    } t_mem_ctl;
endpackage

// File: rtl/core/keyed_ranking_table.sv
// Top level of the keyed ranking table: sequencer plus row memory.
//
// Usage: one input channel (i_in_valid/o_in_stall/i_in_item) carries operations:
// set all factors, set one factor, delete, rank of key, key at rank, factors of key.
// One output channel (o_out_valid/i_out_stall/o_out_item) returns exactly one
// result per operation, in order.
// Rows live in a single-port-read/single-port-write memory kept in rank order.
// A key search reads the stored rows in rank order and checks each key after
// its read. An update then moves the entry by adjacent swaps (read the
// neighbour, compare and write it back, write the moving row); delete moves
// each later row one place up by a read and a write. Key at rank reads one row.
// One operation is in work at a time; the next is accepted once the result
// is in the output register, while that result may still wait to be taken.
// Reset empties the table and clears the active factor count; memory content
// is not cleared and needs no sweep.
// A stalled result holds in the output register; the next result waits for it.
module keyed_ranking_table #(
    parameter int CAPACITY    = krt_pkg::CAPACITY_DEF,
    parameter int NUM_FACTORS = krt_pkg::NUM_FACTORS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  krt_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output krt_pkg::t_out_item  o_out_item
);
    import krt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = 32 * NUM_FACTORS + 32;

    logic          rd, wr;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [RW-1:0] wr_data, rd_data;

    krt_seq #(.CAPACITY(CAPACITY), .NUM_FACTORS(NUM_FACTORS)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_in_item),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item),
        .o_rd      (rd),
        .o_rd_addr (rd_addr),
        .o_wr      (wr),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .i_rd_data (rd_data)
    );

    krt_store #(.CAPACITY(CAPACITY), .NUM_FACTORS(NUM_FACTORS)) u_store (
        .i_clk     (i_clk),
        .i_rd      (rd),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );
endmodule

// File: rtl/core/krt_store.sv
// Row memory: key plus factor word per rank, one write and one registered read port.
module krt_store #(
    parameter int CAPACITY    = krt_pkg::CAPACITY_DEF,
    parameter int NUM_FACTORS = krt_pkg::NUM_FACTORS_DEF,
    parameter int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rd,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic                        i_wr,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [32*NUM_FACTORS+31:0]  i_wr_data,
    output logic [32*NUM_FACTORS+31:0]  o_rd_data
);
    import krt_pkg::*;

    logic [32*NUM_FACTORS+31:0] r_mem [CAPACITY];
    logic [32*NUM_FACTORS+31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/core/krt_seq.sv
// Operation sequencer: key search, bubble moves, delete shift and result build.
module krt_seq #(
    parameter int CAPACITY    = krt_pkg::CAPACITY_DEF,
    parameter int NUM_FACTORS = krt_pkg::NUM_FACTORS_DEF,
    parameter int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW          = $clog2(CAPACITY + 1),
    parameter int RW          = 32 * NUM_FACTORS + 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  krt_pkg::t_in_item    i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output krt_pkg::t_out_item   o_item,
    output logic                 o_rd,
    output logic [AW-1:0]        o_rd_addr,
    output logic                 o_wr,
    output logic [AW-1:0]        o_wr_addr,
    output logic [RW-1:0]        o_wr_data,
    input  logic [RW-1:0]        i_rd_data
);
    import krt_pkg::*;

    localparam int FW  = 32 * NUM_FACTORS;
    localparam int NFW = $clog2(NUM_FACTORS + 1) < 3 ? 3 : $clog2(NUM_FACTORS + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SRD    = 12'b000000000010,
        S_SCHK   = 12'b000000000100,
        S_DISP   = 12'b000000001000,
        S_KREAD  = 12'b000000010000,
        S_NRD    = 12'b000000100000,
        S_NCMP   = 12'b000001000000,
        S_DRD    = 12'b000010000000,
        S_DWR    = 12'b000100000000,
        S_OUT    = 12'b001000000000,
        S_KWAIT  = 12'b010000000000,
        S_HOLD   = 12'b100000000000
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_in, n_in;
    logic [CW-1:0]     r_count, n_count;
    logic [NFW-1:0]    r_active, n_active;
    logic [CW-1:0]     r_idx, n_idx;      // search index / moving row index
    logic [FW-1:0]     r_row_f, n_row_f;  // factors of the moving row
    logic [31:0]       r_row_k, n_row_k;
    logic              r_up, n_up;
    logic              r_found, n_found;
    logic [CW-1:0]     r_at, n_at;
    t_out_item         r_out, n_out;      // result under construction
    t_out_item         r_res, n_res;      // result presented on the output channel
    logic              r_ovalid, n_ovalid;

    logic [31:0]       rd_key;
    logic [FW-1:0]     rd_f;
    logic [FW-1:0]     new_f;
    logic [NFW-1:0]    need;
    logic              need_bad;
    logic [CW-1:0]     nbr;
    int                cmp_res;

    assign rd_key = i_rd_data[RW-1 -: 32];
    assign rd_f   = i_rd_data[FW-1:0];

    // signed lexicographic compare of a against b over active factors
    function automatic int cmp_f(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                 input logic [NFW-1:0] act);
        int r;
        r = 0;
        for (int i = NUM_FACTORS - 1; i >= 0; i--) begin
            if (i < int'(act)) begin
                if ($signed(a[32*i +: 32]) > $signed(b[32*i +: 32])) begin
                    r = 1;
                end else if ($signed(a[32*i +: 32]) < $signed(b[32*i +: 32])) begin
                    r = -1;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        need     = (r_in.kind == OP_SET_ALL) ? NFW'(r_in.factor_count)
                                             : NFW'(r_in.factor_index);
        need_bad = (r_in.kind == OP_SET_ALL)
                 ? (r_in.factor_count == 3'd0 || 32'(r_in.factor_count) > NUM_FACTORS)
                 : (r_in.factor_index == 4'd0 || 32'(r_in.factor_index) > NUM_FACTORS);
        new_f = '0;
        for (int i = 0; i < NUM_FACTORS; i++) begin
            if (i < 4 && i < int'(r_in.factor_count)) begin
                case (i)
                    0:       new_f[32*i +: 32] = r_in.factor_0;
                    1:       new_f[32*i +: 32] = r_in.factor_1;
                    2:       new_f[32*i +: 32] = r_in.factor_2;
                    default: new_f[32*i +: 32] = r_in.factor_3;
                endcase
            end
        end
        nbr     = r_up ? r_idx - CW'(1) : r_idx + CW'(1);
        cmp_res = cmp_f(r_row_f, rd_f, r_active);
    end

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_count  = r_count;
        n_active = r_active;
        n_idx    = r_idx;
        n_row_f  = r_row_f;
        n_row_k  = r_row_k;
        n_up     = r_up;
        n_found  = r_found;
        n_at     = r_at;
        n_out    = r_out;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        o_rd      = 1'b0;
        o_rd_addr = AW'(r_idx);
        o_wr      = 1'b0;
        o_wr_addr = AW'(r_idx);
        o_wr_data = {r_row_k, r_row_f};
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in    = i_item;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_out   = '0;
                    if (i_item.kind == OP_KEY_AT) begin
                        n_state = S_KREAD;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if (r_idx < r_count) begin
                    o_rd      = 1'b1;
                    o_rd_addr = AW'(r_idx);
                    n_state   = S_SCHK;
                end else begin
                    n_state = S_DISP;
                end
            end
            S_SCHK: begin
                if (rd_key == r_in.key) begin
                    n_found = 1'b1;
                    n_at    = r_idx;
                    n_row_f = rd_f;
                    n_state = S_DISP;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SRD;
                end
            end
            S_DISP: begin
                n_state = S_OUT;
                case (r_in.kind) inside
                    OP_SET_ALL, OP_SET_ONE: begin
                        if (need_bad) begin
                            n_out.status = ST_BADIDX;
                        end else if (!r_found && r_count >= CW'(CAPACITY)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            if (need > r_active) begin
                                n_active = need;
                            end
                            n_row_k = r_in.key;
                            if (!r_found) begin
                                n_idx   = r_count;
                                n_count = r_count + CW'(1);
                                n_up    = 1'b1;
                                if (r_in.kind == OP_SET_ALL) begin
                                    n_row_f = new_f;
                                end else begin
                                    n_row_f = '0;
                                    n_row_f[32*(int'(r_in.factor_index)-1) +: 32] =
                                        r_in.factor_0;
                                end
                                o_wr      = 1'b1;
                                o_wr_addr = AW'(r_count);
                                o_wr_data = {r_in.key, n_row_f};
                                n_state   = S_NRD;
                            end else begin
                                n_idx = r_at;
                                n_out.old_position = 11'(r_at + CW'(1));
                                n_out.new_position = 11'(r_at + CW'(1));
                                if (r_in.kind == OP_SET_ALL) begin
                                    n_row_f = new_f;
                                    n_up = cmp_f(new_f, r_row_f, n_active) > 0;
                                    if (cmp_f(new_f, r_row_f, n_active) != 0) begin
                                        n_state = S_NRD;
                                    end
                                end else begin
                                    n_row_f[32*(int'(r_in.factor_index)-1) +: 32] =
                                        r_in.factor_0;
                                    n_up = $signed(r_in.factor_0) >
                                           $signed(r_row_f[32*(int'(r_in.factor_index)-1)
                                                           +: 32]);
                                    if (r_in.factor_0 !=
                                        r_row_f[32*(int'(r_in.factor_index)-1) +: 32]) begin
                                        n_state = S_NRD;
                                    end
                                end
                                if (n_state == S_NRD) begin
                                    o_wr      = 1'b1;
                                    o_wr_addr = AW'(r_at);
                                    o_wr_data = {r_in.key, n_row_f};
                                end
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (!r_found) begin
                            n_out.status = ST_NOTFOUND;
                        end else begin
                            n_out.new_position = 11'(r_at + CW'(1));
                            n_idx   = r_at;
                            n_state = S_DRD;
                        end
                    end
                    OP_RANK: begin
                        if (!r_found) begin
                            n_out.status = ST_NOTFOUND;
                        end else begin
                            n_out.new_position = 11'(r_at + CW'(1));
                        end
                    end
                    OP_FACTORS: begin
                        if (!r_found) begin
                            n_out.status = ST_NOTFOUND;
                        end else begin
                            n_out.out_factor_0 = r_row_f[31:0];
                            if (NUM_FACTORS > 1) n_out.out_factor_1 = r_row_f[32*(1 % NUM_FACTORS) +: 32];
                            if (NUM_FACTORS > 2) n_out.out_factor_2 = r_row_f[32*(2 % NUM_FACTORS) +: 32];
                            if (NUM_FACTORS > 3) n_out.out_factor_3 = r_row_f[32*(3 % NUM_FACTORS) +: 32];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_NRD: begin
                // read the neighbor in the direction of travel
                if ((r_up && r_idx == '0) || (!r_up && r_idx + CW'(1) >= r_count)) begin
                    n_out.new_position = 11'(r_idx + CW'(1));
                    n_state = S_OUT;
                end else begin
                    o_rd      = 1'b1;
                    o_rd_addr = AW'(nbr);
                    n_state   = S_NCMP;
                end
            end
            S_NCMP: begin
                if ((r_up && cmp_res > 0) || (!r_up && cmp_res < 0)) begin
                    o_wr      = 1'b1;
                    o_wr_addr = AW'(r_idx);
                    o_wr_data = i_rd_data;
                    n_idx     = nbr;
                    n_state   = S_HOLD;
                end else begin
                    n_out.new_position = 11'(r_idx + CW'(1));
                    n_state = S_OUT;
                end
            end
            S_HOLD: begin
                // moving row into its new slot
                o_wr      = 1'b1;
                o_wr_addr = AW'(r_idx);
                o_wr_data = {r_row_k, r_row_f};
                n_state   = S_NRD;
            end
            S_DRD: begin
                if (r_idx + CW'(1) < r_count) begin
                    o_rd      = 1'b1;
                    o_rd_addr = AW'(r_idx + CW'(1));
                    n_state   = S_DWR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_OUT;
                end
            end
            S_DWR: begin
                o_wr      = 1'b1;
                o_wr_addr = AW'(r_idx);
                o_wr_data = i_rd_data;
                n_idx     = r_idx + CW'(1);
                n_state   = S_DRD;
            end
            S_KREAD: begin
                if (r_in.position == 11'd0 || CW'(r_in.position) > r_count
                    || 32'(r_in.position) > CAPACITY) begin
                    n_out.status = ST_NOTFOUND;
                    n_state = S_OUT;
                end else begin
                    o_rd      = 1'b1;
                    o_rd_addr = AW'(r_in.position - 11'd1);
                    n_state   = S_KWAIT;
                end
            end
            S_KWAIT: begin
                n_out.result_key = rd_key;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hand over only once the previous result has been taken
                if (!r_ovalid) begin
                    n_res = r_out;
                    n_res.factors_used = 3'(r_active);
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_active <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_active <= n_active;
            r_ovalid <= n_ovalid;
        end
        r_in    <= n_in;
        r_idx   <= n_idx;
        r_row_f <= n_row_f;
        r_row_k <= n_row_k;
        r_up    <= n_up;
        r_found <= n_found;
        r_at    <= n_at;
        r_out   <= n_out;
        r_res   <= n_res;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_res;
endmodule

// File: tb/krt_checker.sv
// Checker for the keyed ranking table: watches both channels, predicts results, compares.
module krt_checker
    import krt_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int NUM_FACTORS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending,
    output int        o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [NUM_FACTORS-1:0][31:0] t_row;

    logic [31:0] tbl_key [CAPACITY];
    t_row        tbl_fac [CAPACITY];
    int          n_rows;
    int          n_active;
    t_out_item   expected_q[$];

    initial begin
        o_errors  = 0;
        o_results = 0;
        n_rows    = 0;
        n_active  = 0;
    end

    assign o_pending = expected_q.size();

    // signed lexicographic compare over the active factors
    function automatic int row_cmp(t_row a, t_row b);
        for (int i = 0; i < NUM_FACTORS; i++) begin
            if (i >= n_active) break;
            if ($signed(a[i]) > $signed(b[i])) return 1;
            if ($signed(a[i]) < $signed(b[i])) return -1;
        end
        return 0;
    endfunction

    function automatic int key_index(logic [31:0] k);
        for (int i = 0; i < n_rows; i++)
            if (tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void row_swap(int a, int b);
        logic [31:0] tk;
        t_row        tf;
        tk = tbl_key[a]; tbl_key[a] = tbl_key[b]; tbl_key[b] = tk;
        tf = tbl_fac[a]; tbl_fac[a] = tbl_fac[b]; tbl_fac[b] = tf;
    endfunction

    function automatic int bubble_up(int idx);
        while (idx > 0 && row_cmp(tbl_fac[idx], tbl_fac[idx-1]) > 0) begin
            row_swap(idx, idx - 1);
            idx--;
        end
        return idx + 1;
    endfunction

    function automatic int bubble_down(int idx);
        while (idx + 1 < n_rows && row_cmp(tbl_fac[idx], tbl_fac[idx+1]) < 0) begin
            row_swap(idx, idx + 1);
            idx++;
        end
        return idx + 1;
    endfunction

    function automatic t_out_item rank_update(t_in_item it);
        t_out_item   r;
        int          need, at, c, j;
        t_row        f;
        logic [31:0] vals[4];
        r = '0;
        f = '0;
        vals = '{it.factor_0, it.factor_1, it.factor_2, it.factor_3};
        case (t_kind'(it.kind)) inside
            OP_SET_ALL, OP_SET_ONE: begin
                need = (it.kind == OP_SET_ALL) ? int'(it.factor_count) : int'(it.factor_index);
                if (need < 1 || need > NUM_FACTORS) begin
                    r.status = ST_BADIDX;
                end else begin
                    at = key_index(it.key);
                    if (at < 0 && n_rows >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        if (need > n_active) n_active = need;
                        if (it.kind == OP_SET_ALL) begin
                            for (int i = 0; i < NUM_FACTORS && i < 4; i++)
                                if (i < it.factor_count) f[i] = vals[i];
                        end
                        j = (it.kind == OP_SET_ALL) ? 0 : need - 1;
                        if (at < 0) begin
                            if (it.kind == OP_SET_ONE) f[j] = it.factor_0;
                            tbl_key[n_rows] = it.key;
                            tbl_fac[n_rows] = f;
                            n_rows++;
                            r.new_position = 11'(bubble_up(n_rows - 1));
                        end else begin
                            r.old_position = 11'(at + 1);
                            r.new_position = 11'(at + 1);
                            if (it.kind == OP_SET_ALL) begin
                                c = row_cmp(f, tbl_fac[at]);
                                if (c != 0) tbl_fac[at] = f;
                            end else begin
                                c = ($signed(it.factor_0) > $signed(tbl_fac[at][j])) ? 1 :
                                    (it.factor_0 == tbl_fac[at][j]) ? 0 : -1;
                                if (c != 0) tbl_fac[at][j] = it.factor_0;
                            end
                            if (c > 0) r.new_position = 11'(bubble_up(at));
                            else if (c < 0) r.new_position = 11'(bubble_down(at));
                        end
                    end
                end
            end
            OP_DELETE: begin
                at = key_index(it.key);
                if (at < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    for (int i = at; i + 1 < n_rows; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_fac[i] = tbl_fac[i+1];
                    end
                    n_rows--;
                    r.new_position = 11'(at + 1);
                end
            end
            OP_RANK: begin
                at = key_index(it.key);
                if (at < 0) r.status = ST_NOTFOUND;
                else r.new_position = 11'(at + 1);
            end
            OP_KEY_AT: begin
                if (it.position < 1 || it.position > n_rows) r.status = ST_NOTFOUND;
                else r.result_key = tbl_key[it.position-1];
            end
            OP_FACTORS: begin
                at = key_index(it.key);
                if (at < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.out_factor_0 = tbl_fac[at][0];
                    if (NUM_FACTORS > 1) r.out_factor_1 = tbl_fac[at][1 % NUM_FACTORS];
                    if (NUM_FACTORS > 2) r.out_factor_2 = tbl_fac[at][2 % NUM_FACTORS];
                    if (NUM_FACTORS > 3) r.out_factor_3 = tbl_fac[at][3 % NUM_FACTORS];
                end
            end
            default: ;
        endcase
        r.factors_used = 3'(n_active);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && i_in_valid && !i_in_stall)
            expected_q.push_back(rank_update(i_in_item));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            o_results <= o_results + 1;
            if (expected_q.size() == 0) begin
                o_errors <= o_errors + 1;
                if (o_errors < 10) $display("ERROR: unexpected result %h", i_out_item);
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r !== i_out_item) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("ERROR: result mismatch\n  exp %h\n  got %h", exp_r, i_out_item);
                end
            end
        end
    end
endmodule

// File: tb/tb_keyed_ranking_table.sv
// Top of the keyed ranking table testbench: stimulus, idling and verdict.
module tb_keyed_ranking_table;
    import krt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 3_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall, out_valid;
    t_out_item out_item;
    int        errors, pending, results;
    int        cycles = 0;
    int        sent = 0;
    bit        hold_done = 1'b0;
    logic [31:0] key_pool[8];

    always #5 i_clk = ~i_clk;

    keyed_ranking_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item)
    );

    krt_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_factor();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(0, 3) - 1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it = '0;
        it.kind = $urandom_range(0, 99) < 45 ? 3'($urandom_range(0, 1))
                                              : 3'($urandom_range(0, 7));
        it.key = $urandom_range(0, 9) == 0 ? $urandom() : key_pool[$urandom_range(0, 7)];
        it.factor_0 = rand_factor();
        it.factor_1 = rand_factor();
        it.factor_2 = rand_factor();
        it.factor_3 = rand_factor();
        it.factor_count = $urandom_range(0, 9) == 0 ? 3'($urandom())
                                                    : 3'($urandom_range(1, 4));
        it.factor_index = $urandom_range(0, 9) == 0 ? 4'($urandom())
                                                    : 4'($urandom_range(1, 4));
        it.position = $urandom_range(0, 9) == 0 ? 11'($urandom())
                                                : 11'($urandom_range(0, 9));
        return it;
    endfunction

    // valid drops only when a gap follows, so it never gets two updates at one edge
    task automatic send(t_in_item it);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic t_in_item mk(t_kind k, logic [31:0] key, logic [31:0] f0,
                                    logic [2:0] cnt, logic [3:0] idx, logic [10:0] pos);
        t_in_item it;
        it = '0;
        it.kind = k; it.key = key; it.factor_0 = f0;
        it.factor_1 = ~f0; it.factor_2 = f0 ^ 32'h5555_5555; it.factor_3 = 32'hffff_ffff;
        it.factor_count = cnt; it.factor_index = idx; it.position = pos;
        return it;
    endfunction

    // receiver: random stalls, one long hold-off and a stall-free window
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent > 60) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end else if (sent > 200 && sent < 240) begin
                out_stall <= 1'b0;
            end else begin
                g = gap_len();
                out_stall <= (g != 0);
                if (g > 1) repeat (g - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hffff_ffff;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: every kind, extreme factors, bad counts, absent keys, ties
        send(mk(OP_RANK, key_pool[0], 0, 1, 1, 0));
        send(mk(OP_KEY_AT, 0, 0, 1, 1, 0));
        send(mk(OP_SET_ALL, key_pool[0], 32'h8000_0000, 0, 1, 0));
        send(mk(OP_SET_ALL, key_pool[0], 32'h8000_0000, 5, 1, 0));
        send(mk(OP_SET_ONE, key_pool[0], 32'h7fff_ffff, 1, 0, 0));
        send(mk(OP_SET_ONE, key_pool[0], 32'h7fff_ffff, 1, 15, 0));
        send(mk(OP_SET_ALL, key_pool[0], 32'h8000_0000, 1, 1, 0));
        send(mk(OP_SET_ALL, key_pool[1], 32'h7fff_ffff, 4, 1, 0));
        send(mk(OP_SET_ONE, key_pool[2], 32'h7fff_ffff, 1, 3, 0));
        send(mk(OP_SET_ALL, key_pool[1], 32'h7fff_ffff, 4, 1, 0));
        send(mk(OP_SET_ONE, key_pool[0], 32'h7fff_ffff, 1, 1, 0));
        send(mk(OP_SET_ONE, key_pool[0], 32'h8000_0000, 1, 1, 0));
        send(mk(OP_SET_ONE, key_pool[1], 32'h7fff_ffff, 1, 4, 0));
        send(mk(OP_SET_ALL, key_pool[3], 0, 2, 1, 0));
        send(mk(OP_KEY_AT, 0, 0, 1, 1, 1));
        send(mk(OP_KEY_AT, 0, 0, 1, 1, 4));
        send(mk(OP_KEY_AT, 0, 0, 1, 1, 5));
        send(mk(OP_KEY_AT, 0, 0, 1, 1, 11'h7ff));
        send(mk(OP_FACTORS, key_pool[1], 0, 1, 1, 0));
        send(mk(OP_FACTORS, key_pool[5], 0, 1, 1, 0));
        send(mk(OP_RANK, key_pool[3], 0, 1, 1, 0));
        send(mk(OP_DELETE, key_pool[2], 0, 1, 1, 0));
        send(mk(OP_DELETE, key_pool[2], 0, 1, 1, 0));
        send(mk(OP_RSVD6, key_pool[3], 0, 1, 1, 0));
        send(mk(OP_RSVD7, key_pool[3], 0, 1, 1, 0));
        repeat (270) send(rand_item());
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d operations of every kind over a small key pool, with extreme", sent);
        $display("factors, bad counts and indexes, and a long output hold; %0d results.", results);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
